// ----- sv/ect_pkg.sv -----
package ect_pkg;

	// Longest variable run that is counted; longer runs saturate and flag overflow.
	localparam int RUN_MAX = 4095;
	localparam int RUN_W = $clog2(RUN_MAX + 1);
	localparam int CNT_W = 12;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Character codes that the classifier looks for.
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		CLS_PUNCT = 3'd0,
		CLS_VAR   = 3'd1,
		CLS_BIN   = 3'd2,
		CLS_NUM   = 3'd3,
		CLS_UNARY = 3'd4,
		CLS_FUNC  = 3'd5,
		CLS_NONE  = 3'd7
	} class_t;

	// One result beat.
	typedef struct packed {
		class_t           cls;
		logic [CNT_W-1:0] cnt;
		logic             ovf;
		logic             done;
	} result_t;

	// What one input character leaves for the back part: an ended run and the character.
	typedef struct packed {
		logic    run_vld;
		result_t run_res;
		logic    tok_vld;
		result_t tok_res;
	} entry_t;

endpackage

// ----- sv/ect_front.sv -----
module ect_front import ect_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] ch,
	input  logic       end_of_statement,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	class_t           prev_class_q;
	logic             prev_close_q;
	logic [RUN_W-1:0] run_q;
	logic             run_ovf_q;

	class_t           cls;
	logic             accept;
	logic [RUN_W-1:0] run_inc;
	logic             ovf_inc;

	// Classify the character against the one-character context.
	always_comb begin
		priority if (ch == CH_LPAREN || ch == CH_RPAREN || ch == CH_COMMA) begin
			cls = CLS_PUNCT;
		end else if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
			cls = (ch == CH_LOW_E && prev_class_q == CLS_NUM) ? CLS_BIN : CLS_VAR;
		end else if (ch == CH_DOT) begin
			cls = CLS_NUM;
		end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
			cls = (prev_class_q == CLS_VAR) ? CLS_VAR : CLS_NUM;
		end else if (ch == CH_PLUS || ch == CH_MINUS) begin
			if (end_of_statement || prev_class_q == CLS_NUM || prev_class_q == CLS_VAR ||
			    (prev_class_q == CLS_PUNCT && prev_close_q)) begin
				cls = CLS_BIN;
			end else begin
				cls = CLS_UNARY;
			end
		end else begin
			cls = CLS_BIN;
		end
	end

	// Saturating run count.
	assign run_inc = (run_q < RUN_W'(RUN_MAX)) ? run_q + RUN_W'(1) : run_q;
	assign ovf_inc = run_ovf_q | (run_q == RUN_W'(RUN_MAX));

	assign accept = push & ~q_full;

	// Build the queue entry for this character.
	always_comb begin
		q_entry = '0;
		if (cls == CLS_VAR) begin
			q_entry.run_vld      = end_of_statement;
			q_entry.run_res.cls  = CLS_VAR;
			q_entry.run_res.cnt  = CNT_W'(run_inc);
			q_entry.run_res.ovf  = ovf_inc;
			q_entry.run_res.done = 1'b1;
		end else begin
			q_entry.run_vld      = (run_q != '0);
			q_entry.run_res.cls  = (ch == CH_LPAREN) ? CLS_FUNC : CLS_VAR;
			q_entry.run_res.cnt  = CNT_W'(run_q);
			q_entry.run_res.ovf  = run_ovf_q;
			q_entry.run_res.done = 1'b0;
			q_entry.tok_vld      = 1'b1;
			q_entry.tok_res.cls  = cls;
			q_entry.tok_res.cnt  = CNT_W'(1);
			q_entry.tok_res.ovf  = 1'b0;
			q_entry.tok_res.done = end_of_statement;
		end
	end

	assign q_push = accept & (q_entry.run_vld | q_entry.tok_vld);

	// Context state; the end of a statement returns it to the start state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= CLS_NONE;
			prev_close_q <= 1'b0;
			run_q        <= '0;
			run_ovf_q    <= 1'b0;
		end else if (accept) begin
			if (end_of_statement) begin
				prev_class_q <= CLS_NONE;
				prev_close_q <= 1'b0;
				run_q        <= '0;
				run_ovf_q    <= 1'b0;
			end else if (cls == CLS_VAR) begin
				prev_class_q <= CLS_VAR;
				prev_close_q <= 1'b0;
				run_q        <= run_inc;
				run_ovf_q    <= ovf_inc;
			end else begin
				prev_class_q <= cls;
				prev_close_q <= (ch == CH_RPAREN);
				run_q        <= '0;
				run_ovf_q    <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/ect_queue.sv -----
module ect_queue import ect_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   rd_en,
	output logic   rd_vld,
	output entry_t rd_entry
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	logic do_wr;
	logic do_rd;

	assign full     = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign rd_vld   = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_vld;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/ect_back.sv -----
module ect_back import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_vld,
	input  entry_t      q_entry,
	output logic        q_pop,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  token_class,
	output logic [11:0] run_count,
	output logic        run_overflow,
	output logic        statement_done
);

	logic    run_vld_q;
	logic    tok_vld_q;
	result_t run_res_q;
	result_t tok_res_q;

	logic    take;
	logic    run_vld_n;
	logic    tok_vld_n;
	result_t head;

	assign empty = ~(run_vld_q | tok_vld_q);
	assign take  = pop & ~empty;

	// The ended run goes out before the character that ended it.
	assign head           = run_vld_q ? run_res_q : tok_res_q;
	assign token_class    = head.cls;
	assign run_count      = head.cnt;
	assign run_overflow   = head.ovf;
	assign statement_done = head.done;

	// Slots left after this cycle's beat.
	always_comb begin
		run_vld_n = run_vld_q;
		tok_vld_n = tok_vld_q;
		if (take) begin
			if (run_vld_q) begin
				run_vld_n = 1'b0;
			end else begin
				tok_vld_n = 1'b0;
			end
		end
	end

	// Refill from the queue as soon as the held entry is used up.
	assign q_pop = q_vld & ~(run_vld_n | tok_vld_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_vld_q <= 1'b0;
			tok_vld_q <= 1'b0;
		end else if (q_pop) begin
			run_vld_q <= q_entry.run_vld;
			tok_vld_q <= q_entry.tok_vld;
		end else begin
			run_vld_q <= run_vld_n;
			tok_vld_q <= tok_vld_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			run_res_q <= q_entry.run_res;
			tok_res_q <= q_entry.tok_res;
		end
	end

endmodule

// ----- sv/expression_char_tagger_top.sv -----
// Channel  | Handshake     | Payload
// ---------+---------------+-------------------------------------------------
// input    | push / full   | ch[7:0], end_of_statement
// result   | empty / pop   | token_class[2:0], run_count[11:0], run_overflow,
//          |               | statement_done
//
// One character is taken per cycle while full is low; classification and the
// run counter sit in the front part. Each character gives zero, one or two
// result beats; the back part sends one beat per cycle while pop is high and
// empty is low, so a non-variable character that ends a run costs two beats.
// A four-entry queue separates the two parts, and the back part holds one
// entry in its output register. No clearing pass follows reset.
module expression_char_tagger_top import ect_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  ch,
	input  logic        end_of_statement,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  token_class,
	output logic [11:0] run_count,
	output logic        run_overflow,
	output logic        statement_done
);

	logic   f_push;
	entry_t f_entry;
	logic   b_pop;
	logic   q_vld;
	entry_t q_entry;

	// Front: classify and count runs.
	ect_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.ch               (ch),
		.end_of_statement (end_of_statement),
		.q_full           (full),
		.q_push           (f_push),
		.q_entry          (f_entry)
	);

	// Queue between the two parts.
	ect_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (f_push),
		.wr_entry (f_entry),
		.full     (full),
		.rd_en    (b_pop),
		.rd_vld   (q_vld),
		.rd_entry (q_entry)
	);

	// Back: send results one beat at a time.
	ect_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_vld          (q_vld),
		.q_entry        (q_entry),
		.q_pop          (b_pop),
		.pop            (pop),
		.empty          (empty),
		.token_class    (token_class),
		.run_count      (run_count),
		.run_overflow   (run_overflow),
		.statement_done (statement_done)
	);

endmodule
